// File: rtl/dcma_pkg.sv
// ----------------------------------------------------------------------------
// Decimated complex moving average: shared package
// Widths, item types, configuration types and register indexes.
// ----------------------------------------------------------------------------
package dcma_pkg;

  localparam int CHANNELS      = 4;
  localparam int WINDOW        = 256;
  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_BITS      = 24;
  localparam int CH_BITS       = 2;
  localparam int POS_BITS      = $clog2(WINDOW);
  localparam int LEN_BITS      = 9;
  localparam int TICK_BITS     = 16;
  localparam int RECIP_BITS    = 16;
  localparam int FRAC_BITS     = 15;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int HIST_DEPTH    = CHANNELS * WINDOW;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int HIST_WIDTH    = 2 * SAMPLE_BITS;
  localparam int PROD_BITS     = SUM_BITS + RECIP_BITS + 1;
  localparam int Q_BITS        = PROD_BITS - FRAC_BITS;

  localparam logic [LEN_BITS-1:0]   WINDOW_LENGTH_RST    = LEN_BITS'(256);
  localparam logic [TICK_BITS-1:0]  TICKS_PER_UPDATE_RST = TICK_BITS'(1);
  localparam logic [RECIP_BITS-1:0] RECIPROCAL_RST       = RECIP_BITS'(128);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_TICKS_PER_UPDATE = 2'd1,
    REG_RECIPROCAL_Q15   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_BITS-1:0]            channel;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0]            out_channel;
    logic signed [SAMPLE_BITS-1:0] mean_re;
    logic signed [SAMPLE_BITS-1:0] mean_im;
  } out_item_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]   window_length;
    logic [TICK_BITS-1:0]  ticks_per_update;
    logic [RECIP_BITS-1:0] reciprocal_q15;
  } cfg_t;

  typedef struct packed {
    logic [CH_BITS-1:0]         channel;
    logic signed [SUM_BITS-1:0] sum_re;
    logic signed [SUM_BITS-1:0] sum_im;
  } sum_item_t;

endpackage

// File: rtl/dcma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dcma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/dcma_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Window length, ticks per update and Q1.15 reciprocal.
// ----------------------------------------------------------------------------
module dcma_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dcma_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [dcma_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output dcma_pkg::cfg_t                     cfg_o
);
  import dcma_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length    <= WINDOW_LENGTH_RST;
      cfg_q.ticks_per_update <= TICKS_PER_UPDATE_RST;
      cfg_q.reciprocal_q15   <= RECIPROCAL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW_LENGTH:    cfg_q.window_length    <= cfg_data_i[LEN_BITS-1:0];
        REG_TICKS_PER_UPDATE: cfg_q.ticks_per_update <= cfg_data_i[TICK_BITS-1:0];
        REG_RECIPROCAL_Q15:   cfg_q.reciprocal_q15   <= cfg_data_i[RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/dcma_accum.sv
// ----------------------------------------------------------------------------
// Window accumulator
// Tick counter, per-channel write positions, history memory and running sums.
// ----------------------------------------------------------------------------
module dcma_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcma_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dcma_pkg::in_item_t   in_item_i,
  output logic                 sum_valid_o,
  input  logic                 sum_ready_i,
  output dcma_pkg::sum_item_t  sum_item_o
);
  import dcma_pkg::*;

  logic                   clr_busy_q;
  logic [HIST_AW-1:0]     clr_addr_q;
  logic [TICK_BITS-1:0]   tick_q;
  logic                   upd_q;
  logic [POS_BITS-1:0]    pos_q [CHANNELS];
  logic [SUM_BITS-1:0]    sum_re_q [CHANNELS];
  logic [SUM_BITS-1:0]    sum_im_q [CHANNELS];

  logic                   s1_valid_q;
  logic [CH_BITS-1:0]     s1_ch_q;
  logic [SAMPLE_BITS-1:0] s1_re_q;
  logic [SAMPLE_BITS-1:0] s1_im_q;
  logic                   s1_upd_q;
  logic [HIST_AW-1:0]     s1_slot_q;
  logic                   fwd_q;
  logic [SAMPLE_BITS-1:0] fwd_re_q;
  logic [SAMPLE_BITS-1:0] fwd_im_q;

  logic                   sum_valid_q;
  sum_item_t              sum_item_q;

  logic                   s2_en, s1_en, s1_leave, accept;
  logic [TICK_BITS-1:0]   tick_inc;
  logic                   tick_hit, item_upd;
  logic [LEN_BITS-1:0]    len_eff, pos_inc;
  logic [POS_BITS-1:0]    pos_cur, pos_next;
  logic [HIST_AW-1:0]     slot;
  logic                   slot_match;
  logic                   ram_we;
  logic [HIST_AW-1:0]     ram_waddr;
  logic [HIST_WIDTH-1:0]  ram_wdata, ram_rdata;
  logic [SAMPLE_BITS-1:0] old_re, old_im;
  logic [SUM_BITS-1:0]    sum_cur_re, sum_cur_im, sum_new_re, sum_new_im;

  assign s2_en      = !sum_valid_q || sum_ready_i;
  assign s1_leave   = s1_valid_q && s2_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en && !clr_busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // frame tick
  assign tick_inc = tick_q + TICK_BITS'(1);
  assign tick_hit = tick_inc >= cfg_i.ticks_per_update;
  assign item_upd = in_item_i.frame_start ? tick_hit : upd_q;

  // write position
  always_comb begin
    if (cfg_i.window_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (cfg_i.window_length > LEN_BITS'(WINDOW)) begin
      len_eff = LEN_BITS'(WINDOW);
    end else begin
      len_eff = cfg_i.window_length;
    end
  end

  assign pos_cur    = pos_q[in_item_i.channel];
  assign pos_inc    = LEN_BITS'(pos_cur) + LEN_BITS'(1);
  assign pos_next   = (pos_inc >= len_eff) ? '0 : pos_inc[POS_BITS-1:0];
  assign slot       = {in_item_i.channel, pos_cur};
  assign slot_match = s1_leave && s1_upd_q && (s1_slot_q == slot);

  // history memory: clearing pass after reset, else stage-1 write-back
  assign ram_we    = clr_busy_q || (s1_leave && s1_upd_q);
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_slot_q;
  assign ram_wdata = clr_busy_q ? '0 : {s1_re_q, s1_im_q};

  dcma_ram #(
    .WIDTH (HIST_WIDTH),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // oldest sample, bypassed when the previous item wrote the same slot
  assign old_re = fwd_q ? fwd_re_q : ram_rdata[HIST_WIDTH-1:SAMPLE_BITS];
  assign old_im = fwd_q ? fwd_im_q : ram_rdata[SAMPLE_BITS-1:0];

  assign sum_cur_re = sum_re_q[s1_ch_q];
  assign sum_cur_im = sum_im_q[s1_ch_q];
  assign sum_new_re = sum_cur_re
                    + {{(SUM_BITS-SAMPLE_BITS){s1_re_q[SAMPLE_BITS-1]}}, s1_re_q}
                    - {{(SUM_BITS-SAMPLE_BITS){old_re[SAMPLE_BITS-1]}}, old_re};
  assign sum_new_im = sum_cur_im
                    + {{(SUM_BITS-SAMPLE_BITS){s1_im_q[SAMPLE_BITS-1]}}, s1_im_q}
                    - {{(SUM_BITS-SAMPLE_BITS){old_im[SAMPLE_BITS-1]}}, old_im};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + HIST_AW'(1);
      if (clr_addr_q == HIST_AW'(HIST_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      upd_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i] <= '0;
      end
    end else if (accept) begin
      if (in_item_i.frame_start) begin
        tick_q <= tick_hit ? '0 : tick_inc;
        upd_q  <= tick_hit;
      end
      if (item_upd) begin
        pos_q[in_item_i.channel] <= pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_re_q[i] <= '0;
        sum_im_q[i] <= '0;
      end
    end else if (s1_leave && s1_upd_q) begin
      sum_re_q[s1_ch_q] <= sum_new_re;
      sum_im_q[s1_ch_q] <= sum_new_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= accept;
      fwd_q      <= accept && item_upd && slot_match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q   <= in_item_i.channel;
      s1_re_q   <= in_item_i.sample_re;
      s1_im_q   <= in_item_i.sample_im;
      s1_upd_q  <= item_upd;
      s1_slot_q <= slot;
      fwd_re_q  <= s1_re_q;
      fwd_im_q  <= s1_im_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (s2_en) begin
      sum_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      sum_item_q.channel <= s1_ch_q;
      sum_item_q.sum_re  <= s1_upd_q ? sum_new_re : sum_cur_re;
      sum_item_q.sum_im  <= s1_upd_q ? sum_new_im : sum_cur_im;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_item_o  = sum_item_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("item accepted during history clear");

  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q && !sum_valid_q)
    else $error("item in flight during history clear");

  a_bypass_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && s1_upd_q)
    else $error("history bypass without an updating item");

  a_clear_ends_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_addr_q) == HIST_AW'(HIST_DEPTH - 1))
    else $error("history clear ended early");

endmodule

// File: rtl/dcma_scale.sv
// ----------------------------------------------------------------------------
// Scaler
// Sums times Q1.15 reciprocal, floor shift and saturation to sample width.
// ----------------------------------------------------------------------------
module dcma_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [dcma_pkg::RECIP_BITS-1:0]   reciprocal_i,
  input  logic                              sum_valid_i,
  output logic                              sum_ready_o,
  input  dcma_pkg::sum_item_t               sum_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dcma_pkg::out_item_t               out_item_o
);
  import dcma_pkg::*;

  logic                        p_valid_q;
  logic [CH_BITS-1:0]          p_ch_q;
  logic signed [PROD_BITS-1:0] p_re_q, p_im_q;
  logic signed [PROD_BITS-1:0] prod_re, prod_im;
  logic signed [RECIP_BITS:0]  recip;
  logic                        out_valid_q;
  out_item_t                   out_q;
  logic                        out_en, p_en;

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic [PROD_BITS-1:0] p);
    logic [Q_BITS-1:0] q;
    logic [Q_BITS-SAMPLE_BITS:0] top;
    q   = p[PROD_BITS-1:FRAC_BITS];
    top = q[Q_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      sat = q[SAMPLE_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  assign out_en      = !out_valid_q || out_ready_i;
  assign p_en        = !p_valid_q || out_en;
  assign sum_ready_o = p_en;

  assign recip   = $signed({1'b0, reciprocal_i});
  assign prod_re = sum_item_i.sum_re * recip;
  assign prod_im = sum_item_i.sum_im * recip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p_en) begin
        p_valid_q <= sum_valid_i;
      end
      if (out_en) begin
        out_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en && sum_valid_i) begin
      p_ch_q <= sum_item_i.channel;
      p_re_q <= prod_re;
      p_im_q <= prod_im;
    end
    if (out_en && p_valid_q) begin
      out_q.out_channel <= p_ch_q;
      out_q.mean_re     <= sat(p_re_q);
      out_q.mean_im     <= sat(p_im_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/decimated_complex_moving_average.sv
// ----------------------------------------------------------------------------
// Decimated complex moving average
// Each item passes the stage-1, sum, product and output registers in order.
// Throughput: one item per cycle unless the output stalls; one history read
// and one write per cycle. Reset clears sums, positions and tick counter at
// once, then a clearing pass zeroes the history; no items enter until it ends.
// Configuration writes are taken in every cycle, also during the clear.
// ----------------------------------------------------------------------------
module decimated_complex_moving_average (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dcma_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [dcma_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  dcma_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dcma_pkg::out_item_t                out_item_o
);
  import dcma_pkg::*;

  cfg_t      cfg;
  logic      sum_valid, sum_ready;
  sum_item_t sum_item;

  dcma_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dcma_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_item_o  (sum_item)
  );

  dcma_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reciprocal_i (cfg.reciprocal_q15),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sum_item_i   (sum_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// File: bench/decimated_complex_moving_average_test.sv
// ----------------------------------------------------------------------------
// Decimated complex moving average: testbench
// Drives complex samples per channel in frames, with random gaps on the input
// and random stalls on the output. A scoreboard keeps its own running sums,
// histories and tick counter, predicts each scaled and saturated mean, and
// compares every result item in order. Runs through several register settings.
// ----------------------------------------------------------------------------
module decimated_complex_moving_average_test;
  import dcma_pkg::*;

  class mean_tracker;
    logic [LEN_BITS-1:0]           window_length;
    logic [TICK_BITS-1:0]          ticks_per_update;
    logic [RECIP_BITS-1:0]         reciprocal;
    logic [TICK_BITS-1:0]          tick_count;
    bit                            frame_updates;
    logic signed [SUM_BITS-1:0]    sum_re[CHANNELS];
    logic signed [SUM_BITS-1:0]    sum_im[CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_re[CHANNELS][WINDOW];
    logic signed [SAMPLE_BITS-1:0] hist_im[CHANNELS][WINDOW];
    logic [POS_BITS-1:0]           wr_pos[CHANNELS];
    out_item_t                     expected_means[$];
    int                            errors;

    function new();
      window_length    = WINDOW_LENGTH_RST;
      ticks_per_update = TICKS_PER_UPDATE_RST;
      reciprocal       = RECIPROCAL_RST;
      tick_count       = '0;
      frame_updates    = 1'b0;
      errors           = 0;
      foreach (sum_re[c]) begin
        sum_re[c] = '0;
        sum_im[c] = '0;
        wr_pos[c] = '0;
      end
      foreach (hist_re[c, p]) begin
        hist_re[c][p] = '0;
        hist_im[c][p] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_WINDOW_LENGTH:    window_length    = data[LEN_BITS-1:0];
        REG_TICKS_PER_UPDATE: ticks_per_update = data[TICK_BITS-1:0];
        REG_RECIPROCAL_Q15:   reciprocal       = data[RECIP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [SAMPLE_BITS-1:0] scale(logic signed [SUM_BITS-1:0] s);
      longint p;
      longint hi;
      hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      p  = longint'(s) * longint'({1'b0, reciprocal});
      p  = p >>> FRAC_BITS;
      if (p > hi) p = hi;
      if (p < -hi - 1) p = -hi - 1;
      return p[SAMPLE_BITS-1:0];
    endfunction

    function void note_sample(in_item_t it);
      int unsigned                   ch;
      int unsigned                   len;
      int unsigned                   pos;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      out_item_t                     want;
      ch = it.channel;
      re = it.sample_re;
      im = it.sample_im;
      if (it.frame_start) begin
        tick_count    = tick_count + 1'b1;
        frame_updates = (tick_count >= ticks_per_update);
        if (frame_updates) tick_count = '0;
      end
      if (frame_updates) begin
        len = window_length;
        if (len == 0) len = 1;
        if (len > WINDOW) len = WINDOW;
        pos = wr_pos[ch];
        sum_re[ch] = SUM_BITS'(longint'(sum_re[ch]) + longint'(re) - longint'(hist_re[ch][pos]));
        sum_im[ch] = SUM_BITS'(longint'(sum_im[ch]) + longint'(im) - longint'(hist_im[ch][pos]));
        hist_re[ch][pos] = re;
        hist_im[ch][pos] = im;
        pos++;
        if (pos >= len) pos = 0;
        wr_pos[ch] = POS_BITS'(pos);
      end
      want.out_channel = it.channel;
      want.mean_re     = scale(sum_re[ch]);
      want.mean_im     = scale(sum_im[ch]);
      expected_means.push_back(want);
    endfunction

    function void check_mean(out_item_t got);
      out_item_t want;
      if (expected_means.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result item ch %0d re %0d im %0d",
                   got.out_channel, got.mean_re, got.mean_im);
        return;
      end
      want = expected_means.pop_front();
      if (got.out_channel !== want.out_channel || got.mean_re !== want.mean_re ||
          got.mean_im !== want.mean_im) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ch %0d re %0d im %0d, got ch %0d re %0d im %0d",
                   want.out_channel, want.mean_re, want.mean_im,
                   got.out_channel, got.mean_re, got.mean_im);
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    function void close_out();
      if (expected_means.size() != 0) begin
        $display("%0d result items never arrived", expected_means.size());
        errors += expected_means.size();
      end
    endfunction
  endclass

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item     = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  out_item_t                out_item;
  bit                       in_eager    = 1'b0;
  bit                       out_eager   = 1'b0;
  mean_tracker              sb          = new();

  decimated_complex_moving_average u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_item(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] re,
                           logic [SAMPLE_BITS-1:0] im, bit fs);
    int       gap;
    in_item_t it;
    it.channel     = ch;
    it.sample_re   = re;
    it.sample_im   = im;
    it.frame_start = fs;
    gap = in_eager ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(it);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int wl, int tpu, int rec);
    drain();
    cfg_write(REG_WINDOW_LENGTH, CFG_DATA_BITS'(wl));
    cfg_write(REG_TICKS_PER_UPDATE, CFG_DATA_BITS'(tpu));
    cfg_write(REG_RECIPROCAL_Q15, CFG_DATA_BITS'(rec));
    cfg_valid <= 1'b0;
    in_eager  = ($urandom_range(0, 3) == 0);
    out_eager = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return SAMPLE_BITS'($urandom_range(0, 15)) - 16'd8;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly whole frames over all channels, some stray items
  task automatic run_random(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) != 0) begin
        for (int c = 0; c < CHANNELS; c++)
          send_item(CH_BITS'(c), rand_sample(), rand_sample(), c == 0);
        sent += CHANNELS;
      end else begin
        send_item(CH_BITS'($urandom_range(0, CHANNELS - 1)), rand_sample(),
                  rand_sample(), $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      int gap;
      gap = out_eager ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_mean(out_item);
    end
  end

  initial begin
    int wl_set[9];
    int tpu_set[9];
    int rec_set[9];
    wl_set  = '{8, 3, 300, 0, 256, 5, 16, 1, 2};
    tpu_set = '{1, 1, 2, 0, 1, 3, 65535, 1, 1};
    rec_set = '{4096, 10923, 128, 65535, 128, 6554, 2048, 32768, 65535};
    repeat (12) @(posedge clk);

    // reset settings: nothing updates before the first frame start
    send_item(2'd0, 16'h7fff, 16'h8000, 1'b0);
    send_item(2'd1, 16'h8000, 16'h7fff, 1'b0);
    send_item(2'd2, 16'h0000, 16'h0000, 1'b0);
    send_item(2'd3, 16'hffff, 16'h0001, 1'b0);
    send_item(2'd0, 16'h7fff, 16'h8000, 1'b1);
    send_item(2'd1, 16'h8000, 16'h7fff, 1'b0);
    send_item(2'd2, 16'h5555, 16'haaaa, 1'b0);
    send_item(2'd3, 16'haaaa, 16'h5555, 1'b0);

    // window of one, unity scale, zero ticks
    set_config(1, 0, 32768);
    send_item(2'd0, 16'h8000, 16'h7fff, 1'b1);
    send_item(2'd1, 16'h7fff, 16'h8000, 1'b0);
    send_item(2'd3, 16'h0001, 16'hffff, 1'b0);
    send_item(2'd2, 16'h1234, 16'hedcb, 1'b0);

    // reciprocal above one: saturation both ways
    set_config(2, 1, 65535);
    send_item(2'd0, 16'h7fff, 16'h7fff, 1'b1);
    send_item(2'd0, 16'h7fff, 16'h7fff, 1'b0);
    send_item(2'd1, 16'h8000, 16'h8000, 1'b0);
    send_item(2'd1, 16'h8000, 16'h8000, 1'b0);

    // zero window length acts as one
    set_config(0, 1, 32768);
    send_item(2'd2, 16'd5, 16'hfffb, 1'b1);
    send_item(2'd2, 16'd7, 16'hfff9, 1'b0);

    // window above the maximum, frames not updating
    set_config(300, 65535, 16384);
    send_item(2'd1, 16'd100, 16'd200, 1'b1);
    send_item(2'd0, 16'd300, 16'd400, 1'b0);

    foreach (wl_set[i]) begin
      set_config(wl_set[i], tpu_set[i], rec_set[i]);
      run_random(72);
    end
    repeat (2) begin
      set_config($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(1, 12),
                 $urandom_range(0, 3), $urandom_range(0, 65535));
      run_random(72);
    end

    drain();
    sb.close_out();
    if (sb.errors == 0)
      $display("decimated_complex_moving_average_test: done, clean");
    else
      $display("decimated_complex_moving_average_test: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("decimated_complex_moving_average_test: done, errors");
    $finish;
  end

endmodule
